// ===== design/calendar_date_difference_macros.svh =====
// ----------------------------------------------------------------------------
// Calendar date difference assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DIFFERENCE_MACROS_SVH
`define CALENDAR_DATE_DIFFERENCE_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define CDD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define CDD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CDD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date difference package
// Field widths, calendar constants and the cumulative month table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  // A day number for any 14-bit year stays below 2^23.
  localparam int unsigned DN_W = 23;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam logic [DN_W-1:0]    DAYS_PER_YEAR = DN_W'(365);
  localparam logic [DN_W-1:0]    COUNT_MAX     = DN_W'((2 ** COUNT_W) - 1);
  localparam logic [MONTH_W-1:0] MONTH_FIRST   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_LAST    = MONTH_W'(12);

  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every dividend below 2^20 / 24, which covers all years.
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam int unsigned RECIP_100_I  = ((2 ** RECIP_SHIFT) + 99) / 100;
  localparam int unsigned RECIP_PROD_W = YEAR_W + $clog2(RECIP_100_I + 1);
  localparam int unsigned Q100_W       = RECIP_PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_PROD_W-1:0] RECIP_100 = RECIP_PROD_W'(RECIP_100_I);

  localparam int unsigned CUM_W = 9;

  // Days elapsed before the first of each month; row 1 is for leap years.
  localparam logic [CUM_W-1:0] CUM_DAYS [2][12] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
  };

endpackage

// ===== design/cdd_day_number.sv =====
// ----------------------------------------------------------------------------
// Calendar date difference: day number
// Converts a clean date into days counted from the start of year 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdd_day_number (
  input  logic [cdd_pkg::YEAR_W-1:0]  year_i,
  input  logic [cdd_pkg::MONTH_W-1:0] month_i,
  input  logic [cdd_pkg::DAY_W-1:0]   day_i,
  output logic [cdd_pkg::DN_W-1:0]    day_num_o
);

  import cdd_pkg::*;

  logic [YEAR_W-1:0]       prev_year;
  logic [RECIP_PROD_W-1:0] prod_year;
  logic [RECIP_PROD_W-1:0] prod_prev;
  logic [Q100_W-1:0]       cent_year;
  logic [Q100_W-1:0]       cent_prev;
  logic                    year_zero;
  logic                    div4;
  logic                    div100;
  logic                    div400;
  logic                    leap;
  logic [DN_W-1:0]         base_calc;
  logic [DN_W-1:0]         base;
  logic [MONTH_W-1:0]      month_idx;
  logic [CUM_W-1:0]        cum_days;

  assign year_zero = (year_i == '0);
  assign prev_year = year_i - YEAR_W'(1);

  assign prod_year = RECIP_PROD_W'(year_i) * RECIP_100;
  assign prod_prev = RECIP_PROD_W'(prev_year) * RECIP_100;
  assign cent_year = prod_year[RECIP_PROD_W-1:RECIP_SHIFT];
  assign cent_prev = prod_prev[RECIP_PROD_W-1:RECIP_SHIFT];

  // The year is a multiple of 100 exactly when its hundreds count differs
  // from that of the year before.
  assign div4   = (year_i[1:0] == 2'b00);
  assign div100 = (cent_year != cent_prev);
  assign div400 = div100 && (cent_year[1:0] == 2'b00);
  assign leap   = year_zero || (div4 && !div100) || div400;

  // Year 0 is a leap year, so every later year starts one day further on.
  assign base_calc = DN_W'(year_i) * DAYS_PER_YEAR
                   + DN_W'(prev_year[YEAR_W-1:2])
                   - DN_W'(cent_prev)
                   + DN_W'(cent_prev[Q100_W-1:2])
                   + DN_W'(1);
  assign base = year_zero ? '0 : base_calc;

  assign month_idx = month_i - MONTH_FIRST;
  assign cum_days  = CUM_DAYS[leap][month_idx];

  assign day_num_o = base + DN_W'(cum_days) + DN_W'(day_i);

endmodule

// ===== design/calendar_date_difference.sv =====
// ----------------------------------------------------------------------------
// Calendar date difference
// Number of days between two Gregorian dates, one date pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block accepts one date pair every cycle while in_stall_o is low and
// returns one day count for each, in order. A pair lands in an input
// register, both dates are turned into day numbers by closed-form logic in
// a single stage, and the count is held in a result register. A result is
// valid once its item reaches that register and is taken at a clock edge
// where out_stall_i is low. Input stall rises only while both registers are
// full and the result is stalled. Years above MAX_YEAR are clamped to it,
// months below 1 or above 12 are clamped into range, and days are used as
// given. The dates are ordered by year, month and day first; a count that would
// be negative for ordered dates reads as 0, and one beyond 22 bits saturates.
`timescale 1ns / 1ps

`include "calendar_date_difference_macros.svh"

module calendar_date_difference #(
  parameter int unsigned MAX_YEAR = cdd_pkg::MAX_YEAR_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cdd_pkg::YEAR_W-1:0]  first_year_i,
  input  logic [cdd_pkg::MONTH_W-1:0] first_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]   first_day_i,
  input  logic [cdd_pkg::YEAR_W-1:0]  second_year_i,
  input  logic [cdd_pkg::MONTH_W-1:0] second_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]   second_day_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cdd_pkg::COUNT_W-1:0] day_count_o
);

  import cdd_pkg::*;

  localparam int unsigned YEAR_TOP = (2 ** YEAR_W) - 1;
  localparam logic [YEAR_W-1:0] YEAR_CAP =
    YEAR_W'((MAX_YEAR > YEAR_TOP) ? YEAR_TOP : MAX_YEAR);

  logic                in_vld_q, in_vld_d;
  logic [YEAR_W-1:0]   y1_q, y2_q;
  logic [MONTH_W-1:0]  m1_q, m2_q;
  logic [DAY_W-1:0]    d1_q, d2_q;
  logic                out_vld_q, out_vld_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  logic                adv_out;
  logic                in_load;
  logic                cnt_load;

  logic [YEAR_W-1:0]   y1_fix, y2_fix;
  logic [MONTH_W-1:0]  m1_fix, m2_fix;
  logic [DN_W-1:0]     dn1, dn2;
  logic [DN_W-1:0]     dn_hi, dn_lo;
  logic [DN_W-1:0]     diff;
  logic                first_later;
  logic                same_date;

  // Handshake: the result register frees up when empty or being taken.
  assign adv_out     = !out_vld_q || !out_stall_i;
  assign in_stall_o  = in_vld_q && !adv_out;
  assign in_load     = in_valid_i && !in_stall_o;
  assign cnt_load    = adv_out && in_vld_q;
  assign out_valid_o = out_vld_q;
  assign day_count_o = cnt_q;

  always_comb begin
    in_vld_d = in_vld_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv_out) begin
      out_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      y1_q <= first_year_i;
      m1_q <= first_month_i;
      d1_q <= first_day_i;
      y2_q <= second_year_i;
      m2_q <= second_month_i;
      d2_q <= second_day_i;
    end
    if (cnt_load) begin
      cnt_q <= cnt_d;
    end
  end

  // Clean up the registered dates before anything else looks at them.
  always_comb begin
    y1_fix = (y1_q > YEAR_CAP) ? YEAR_CAP : y1_q;
    y2_fix = (y2_q > YEAR_CAP) ? YEAR_CAP : y2_q;
    m1_fix = m1_q;
    m2_fix = m2_q;
    if (m1_q < MONTH_FIRST) begin
      m1_fix = MONTH_FIRST;
    end else if (m1_q > MONTH_LAST) begin
      m1_fix = MONTH_LAST;
    end
    if (m2_q < MONTH_FIRST) begin
      m2_fix = MONTH_FIRST;
    end else if (m2_q > MONTH_LAST) begin
      m2_fix = MONTH_LAST;
    end
  end

  cdd_day_number u_day_num_first (
    .year_i    (y1_fix),
    .month_i   (m1_fix),
    .day_i     (d1_q),
    .day_num_o (dn1)
  );

  cdd_day_number u_day_num_second (
    .year_i    (y2_fix),
    .month_i   (m2_fix),
    .day_i     (d2_q),
    .day_num_o (dn2)
  );

  assign first_later = {y1_fix, m1_fix, d1_q} > {y2_fix, m2_fix, d2_q};
  assign same_date   = (y1_fix == y2_fix) && (m1_fix == m2_fix) && (d1_q == d2_q);

  // Ordered dates can still give a negative span when the days run past
  // the month lengths; that case reads as zero.
  always_comb begin
    dn_hi = first_later ? dn1 : dn2;
    dn_lo = first_later ? dn2 : dn1;
    diff  = (dn_hi >= dn_lo) ? (dn_hi - dn_lo) : '0;
    if (diff > COUNT_MAX) begin
      cnt_d = COUNT_MAX[COUNT_W-1:0];
    end else begin
      cnt_d = diff[COUNT_W-1:0];
    end
  end

  `CDD_ASSERT(a_stall_full, clk_i, rst_ni, in_stall_o |-> (out_vld_q && out_stall_i), "bad stall")
  `CDD_ASSERT(a_item_moves, clk_i, rst_ni, cnt_load |=> out_valid_o, "item lost")
  `CDD_ASSERT(a_same_zero, clk_i, rst_ni, (cnt_load && same_date) |=> day_count_o == '0, "nonzero")
  `CDD_ASSERT_NEVER(a_no_phantom, clk_i, rst_ni, out_vld_q && !$past(out_vld_q || in_vld_q), "no item")

endmodule
